FILE: src/pocc_pkg.sv
package pocc_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned SUM_W      = 48;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned GATHER_W   = 24;
    localparam int unsigned POS_W      = 2;
    localparam int unsigned COUNT_W    = 17;
    localparam int unsigned S_TDATA_W  = 24;
    localparam int unsigned M_TDATA_W  = 32;

    localparam logic [POS_W-1:0]   POS_FULL  = 2'd3;
    localparam logic [POS_W-1:0]   POS_ONE   = 2'd1;
    localparam logic [POS_W-1:0]   POS_TWO   = 2'd2;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef logic [SUM_W-1:0] sum_t;

    function automatic sum_t tail_value(input logic [GATHER_W-1:0] gather,
                                        input logic [POS_W-1:0] pos);
        logic [16:0] pair;
        sum_t        result;
        pair   = {1'b0, gather[23:8]} + {9'd0, gather[7:0]};
        result = '0;
        case (pos)
            POS_ONE:  result = {40'd0, gather[7:0]};
            POS_TWO:  result = {32'd0, gather[15:0]};
            POS_FULL: result = {31'd0, pair};
            default:  result = '0;
        endcase
        return result;
    endfunction

endpackage

FILE: src/packet_ones_complement_checksum.sv
// The packet sum is held in final_reg, then folded and inverted into cks_reg.
// One byte per cycle while s_tready is high; one accumulator add per accepted byte.
// Two result registers part the sides, so s_tready drops only when both hold
// results and m_tready is low.
// Reset: synchronous, active low; clears the accumulator, counters and held settings.
module packet_ones_complement_checksum (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // data_byte[7:0], header_length[15:8], include_payload[16], zero[23:17]
    input  logic [pocc_pkg::S_TDATA_W-1:0]   s_tdata,
    // first_byte[0]
    input  logic                             s_tuser,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // checksum[31:0]
    output logic [pocc_pkg::M_TDATA_W-1:0]   m_tdata,
    // checksum_is_zero[0]
    output logic                             m_tuser
);
    import pocc_pkg::*;

    sum_t                  sum_reg, sum_next;
    logic [GATHER_W-1:0]   gather_reg, gather_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [COUNT_W-1:0]    seen_reg, seen_next;
    logic [BYTE_W-1:0]     hdr_reg, hdr_next;
    logic                  whole_reg, whole_next;

    sum_t                  final_reg, final_next;
    logic                  p1_valid_reg, p1_valid_next;
    logic [WORD_W-1:0]     cks_reg, cks_next;
    logic                  zero_reg, zero_next;
    logic                  m_valid_reg, m_valid_next;

    logic [BYTE_W-1:0]     in_byte;
    logic                  in_accept;
    logic                  out_ready;
    logic                  p1_advance;
    sum_t                  eff_sum;
    logic [GATHER_W-1:0]   eff_gather;
    logic [POS_W-1:0]      eff_pos;
    logic [COUNT_W-1:0]    eff_seen;
    logic                  counted;
    logic [GATHER_W-1:0]   upd_gather;
    logic [POS_W-1:0]      upd_pos;
    sum_t                  addend;
    sum_t                  upd_sum;
    logic [WORD_W:0]       fold_sum;
    logic [WORD_W-1:0]     folded;

    assign in_byte    = s_tdata[7:0];
    assign out_ready  = !m_valid_reg || m_tready;
    assign p1_advance = p1_valid_reg && out_ready;
    assign s_tready   = !p1_valid_reg || out_ready;
    assign in_accept  = s_tvalid && s_tready;

    always_comb begin
        hdr_next   = hdr_reg;
        whole_next = whole_reg;
        eff_sum    = sum_reg;
        eff_gather = gather_reg;
        eff_pos    = pos_reg;
        eff_seen   = seen_reg;
        if (s_tuser) begin
            hdr_next   = s_tdata[15:8];
            whole_next = s_tdata[16];
            eff_sum    = '0;
            eff_gather = '0;
            eff_pos    = '0;
            eff_seen   = '0;
        end
        counted    = whole_next || (eff_seen < {{(COUNT_W-BYTE_W){1'b0}}, hdr_next});
        upd_gather = eff_gather;
        upd_pos    = eff_pos;
        addend     = '0;
        if (counted) begin
            if (eff_pos == POS_FULL) begin
                addend     = {{(SUM_W-WORD_W){1'b0}}, eff_gather, in_byte};
                upd_gather = '0;
                upd_pos    = '0;
            end else begin
                upd_gather = {eff_gather[15:0], in_byte};
                upd_pos    = eff_pos + POS_ONE;
            end
        end
        if (s_tlast) begin
            addend = addend + tail_value(upd_gather, upd_pos);
        end
        upd_sum   = eff_sum + addend;
        seen_next = (eff_seen < COUNT_MAX) ? eff_seen + 1'b1 : eff_seen;
        if (s_tlast) begin
            sum_next    = '0;
            gather_next = '0;
            pos_next    = '0;
            seen_next   = '0;
        end else begin
            sum_next    = upd_sum;
            gather_next = upd_gather;
            pos_next    = upd_pos;
        end
    end

    always_comb begin
        fold_sum = {1'b0, final_reg[WORD_W-1:0]}
                 + {{(WORD_W+1-(SUM_W-WORD_W)){1'b0}}, final_reg[SUM_W-1:WORD_W]};
        folded   = fold_sum[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, fold_sum[WORD_W]};
        cks_next  = p1_advance ? ~folded : cks_reg;
        zero_next = p1_advance ? (folded == '1) : zero_reg;
        final_next = (in_accept && s_tlast) ? upd_sum : final_reg;
        if (in_accept && s_tlast) begin
            p1_valid_next = 1'b1;
        end else if (p1_advance) begin
            p1_valid_next = 1'b0;
        end else begin
            p1_valid_next = p1_valid_reg;
        end
        if (p1_advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg      <= '0;
            gather_reg   <= '0;
            pos_reg      <= '0;
            seen_reg     <= '0;
            hdr_reg      <= '0;
            whole_reg    <= 1'b0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (in_accept) begin
                sum_reg    <= sum_next;
                gather_reg <= gather_next;
                pos_reg    <= pos_next;
                seen_reg   <= seen_next;
                hdr_reg    <= hdr_next;
                whole_reg  <= whole_next;
            end
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        final_reg <= final_next;
        cks_reg   <= cks_next;
        zero_reg  <= zero_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = cks_reg;
    assign m_tuser  = zero_reg;

endmodule
